/* src/bpa_pkg.sv */
package bpa_pkg;

    // pool geometry
    localparam int POOL_LEVELS = 10;
    localparam int POOL_PAGES  = 1 << POOL_LEVELS;
    localparam int NODE_COUNT  = 2 * POOL_PAGES - 1;
    localparam int NODE_W      = POOL_LEVELS + 1;
    localparam int VAL_W       = POOL_LEVELS + 1;
    localparam int LVL_W       = $clog2(POOL_LEVELS + 1);

    // word field widths
    localparam int COUNT_W = 16;
    localparam int PAGE_W  = 10;

    // request kinds
    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FREE   = 2'd1,
        STATUS_BAD_COUNT = 2'd2,
        STATUS_NOT_ALLOC = 2'd3
    } status_t;

    typedef struct packed {
        logic               action;
        logic [COUNT_W-1:0] page_count;
        logic [PAGE_W-1:0]  first_page;
    } bpa_in_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_start;
        status_t           status;
    } bpa_out_t;

    // tree memory access: one write and one read per cycle
    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [NODE_W-1:0] raddr;
    } bpa_mem_req_t;

endpackage

/* src/buddy_page_allocator_unit.sv */
// Buddy page allocator over a pool of 1024 pages, kept as a binary tree of 2047 nodes in one
// on-chip memory, each node holding the largest free power-of-two block below it. After reset
// the block runs a clearing pass, one node per cycle, and s_ready stays low until it is done.
// A word is then taken whenever the sequencer is idle, even while the last result still waits
// in the output register. The tree walk down and the ancestor fix-up each cost one memory read
// per level, and the single read port of the tree memory sets their pace. Results come out in
// request order, one per word.
module buddy_page_allocator_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bpa_pkg::bpa_in_t     s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bpa_pkg::bpa_out_t    m_result
);
    import bpa_pkg::*;

    bpa_mem_req_t      mem_req;
    logic [VAL_W-1:0]  rd_data;
    logic              res_valid;
    logic              res_ready;
    bpa_out_t          res;
    logic              m_valid_reg;
    bpa_out_t          m_result_reg;

    bpa_tree_mem u_tree_mem (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    bpa_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_valid),
        .item_ready (s_ready),
        .item       (s_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

/* src/bpa_tree_mem.sv */
module bpa_tree_mem (
    input  logic                         aclk,
    input  bpa_pkg::bpa_mem_req_t        mem_req,
    output logic [bpa_pkg::VAL_W-1:0]    rd_data
);
    import bpa_pkg::*;

    logic [VAL_W-1:0] mem [NODE_COUNT];
    logic [VAL_W-1:0] rd_data_reg;

    // largest free block per node, registered read
    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rd_data_reg <= mem[mem_req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bpa_seq.sv */
module bpa_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  bpa_pkg::bpa_in_t             item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bpa_pkg::bpa_out_t            res,
    output bpa_pkg::bpa_mem_req_t        mem_req,
    input  logic [bpa_pkg::VAL_W-1:0]    rd_data
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_ROOT_RD,
        ST_ROOT,
        ST_WALK,
        ST_LEAF,
        ST_FREE_RD,
        ST_FREE_NODE,
        ST_FREE_LEFT,
        ST_CLIMB,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    bpa_in_t                 item_reg, item_next;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [POOL_LEVELS-1:0]  pos_reg, pos_next;
    logic [LVL_W-1:0]        r_reg, r_next;
    logic [LVL_W-1:0]        target_reg, target_next;
    logic [VAL_W-1:0]        p_reg, p_next;
    logic [NODE_W-1:0]       idx_reg, idx_next;
    logic [LVL_W-1:0]        depth_reg, depth_next;
    logic [VAL_W-1:0]        val_reg, val_next;
    logic [PAGE_W-1:0]       start_reg, start_next;
    status_t                 status_reg, status_next;

    // ceil(log2(count)) for count 1..POOL_PAGES
    function automatic logic [LVL_W-1:0] round_log(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] m;
        logic [LVL_W-1:0]   r;
        m = c - COUNT_W'(1);
        r = '0;
        for (int i = 0; i < POOL_LEVELS; i++) begin
            if (m[i]) begin
                r = LVL_W'(i + 1);
            end
        end
        return r;
    endfunction

    // index of the first node of a tree level
    function automatic logic [NODE_W-1:0] level_base(input logic [LVL_W-1:0] l);
        return (NODE_W'(1) << l) - NODE_W'(1);
    endfunction

    function automatic logic [NODE_W-1:0] sibling(input logic [NODE_W-1:0] i);
        return i[0] ? i + NODE_W'(1) : i - NODE_W'(1);
    endfunction

    logic                 bad_count;
    logic [LVL_W-1:0]     dec_r;
    logic [LVL_W-1:0]     dec_target;
    logic [NODE_W-1:0]    left_idx;
    logic [NODE_W-1:0]    walk_idx;
    logic [LVL_W-1:0]     walk_depth;
    logic [VAL_W-1:0]     left_v;
    logic [VAL_W-1:0]     right_v;
    logic [VAL_W-1:0]     half;
    logic [VAL_W-1:0]     merged;
    logic [NODE_W-1:0]    up_idx;
    logic [NODE_W-1:0]    leaf_off;
    logic                 climb_go;
    logic [VAL_W-1:0]     climb_val;

    // request decode
    always_comb begin
        bad_count  = (item_reg.page_count == '0) ||
                     ({1'b0, item_reg.page_count} > (COUNT_W + 1)'(POOL_PAGES));
        dec_r      = round_log(item_reg.page_count);
        dec_target = LVL_W'(POOL_LEVELS) - dec_r;
    end

    // walk down: pick left child when it can hold the block
    always_comb begin
        left_idx   = (idx_reg << 1) + NODE_W'(1);
        walk_idx   = (rd_data >= p_reg) ? left_idx : left_idx + NODE_W'(1);
        walk_depth = depth_reg + LVL_W'(1);
        leaf_off   = (idx_reg - level_base(target_reg)) << r_reg;
    end

    // parent merge for the climb
    always_comb begin
        left_v  = idx_reg[0] ? val_reg : rd_data;
        right_v = idx_reg[0] ? rd_data : val_reg;
        half    = VAL_W'(POOL_PAGES) >> depth_reg;
        up_idx  = (idx_reg - NODE_W'(1)) >> 1;
        if (left_v == half && right_v == half) begin
            merged = half << 1;
        end else begin
            merged = (left_v > right_v) ? left_v : right_v;
        end
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        lvl_next    = lvl_reg;
        pos_next    = pos_reg;
        r_next      = r_reg;
        target_next = target_reg;
        p_next      = p_reg;
        idx_next    = idx_reg;
        depth_next  = depth_reg;
        val_next    = val_reg;
        start_next  = start_reg;
        status_next = status_reg;
        mem_req     = '0;
        item_ready  = 1'b0;
        res_valid   = 1'b0;
        climb_go    = 1'b0;
        climb_val   = '0;

        case (state_reg)
            ST_INIT: begin
                // clearing pass: every node gets its subtree size
                mem_req.we    = 1'b1;
                mem_req.waddr = level_base(lvl_reg) + NODE_W'(pos_reg);
                mem_req.wdata = VAL_W'(POOL_PAGES) >> lvl_reg;
                if ({1'b0, pos_reg} == level_base(lvl_reg)) begin
                    pos_next = '0;
                    lvl_next = lvl_reg + LVL_W'(1);
                    if (lvl_reg == LVL_W'(POOL_LEVELS)) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    pos_next = pos_reg + POOL_LEVELS'(1);
                end
            end
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    item_next  = item;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                r_next      = dec_r;
                target_next = dec_target;
                p_next      = VAL_W'(1) << dec_r;
                start_next  = '0;
                status_next = STATUS_OK;
                if (bad_count) begin
                    status_next = STATUS_BAD_COUNT;
                    state_next  = ST_DONE;
                end else if (item_reg.action == ACTION_ALLOC) begin
                    idx_next   = '0;
                    depth_next = '0;
                    state_next = ST_ROOT_RD;
                end else begin
                    idx_next   = level_base(dec_target) +
                                 (NODE_W'(item_reg.first_page) >> dec_r);
                    depth_next = dec_target;
                    state_next = ST_FREE_RD;
                end
            end
            ST_ROOT_RD: begin
                mem_req.raddr = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                if (rd_data < p_reg) begin
                    status_next = STATUS_NO_FREE;
                    state_next  = ST_DONE;
                end else if (target_reg == '0) begin
                    mem_req.raddr = '0;
                    state_next    = ST_LEAF;
                end else begin
                    mem_req.raddr = NODE_W'(1);
                    state_next    = ST_WALK;
                end
            end
            ST_WALK: begin
                idx_next   = walk_idx;
                depth_next = walk_depth;
                if (walk_depth < target_reg) begin
                    mem_req.raddr = (walk_idx << 1) + NODE_W'(1);
                end else begin
                    mem_req.raddr = walk_idx;
                    state_next    = ST_LEAF;
                end
            end
            ST_LEAF: begin
                if (rd_data != p_reg) begin
                    status_next = STATUS_NO_FREE;
                    state_next  = ST_DONE;
                end else begin
                    start_next = leaf_off[PAGE_W-1:0];
                    climb_go   = 1'b1;
                end
            end
            ST_FREE_RD: begin
                mem_req.raddr = idx_reg;
                state_next    = ST_FREE_NODE;
            end
            ST_FREE_NODE: begin
                if (rd_data != '0) begin
                    status_next = STATUS_NOT_ALLOC;
                    state_next  = ST_DONE;
                end else if (target_reg < LVL_W'(POOL_LEVELS)) begin
                    mem_req.raddr = left_idx;
                    state_next    = ST_FREE_LEFT;
                end else begin
                    climb_go  = 1'b1;
                    climb_val = p_reg;
                end
            end
            ST_FREE_LEFT: begin
                if (rd_data != (p_reg >> 1)) begin
                    status_next = STATUS_NOT_ALLOC;
                    state_next  = ST_DONE;
                end else begin
                    climb_go  = 1'b1;
                    climb_val = p_reg;
                end
            end
            ST_CLIMB: begin
                // write parent, fetch the parent's sibling in the same cycle
                mem_req.we    = 1'b1;
                mem_req.waddr = up_idx;
                mem_req.wdata = merged;
                idx_next      = up_idx;
                depth_next    = depth_reg - LVL_W'(1);
                val_next      = merged;
                if (up_idx == '0) begin
                    state_next = ST_DONE;
                end else begin
                    mem_req.raddr = sibling(up_idx);
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // mark the found node and start the climb toward the root
        if (climb_go) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_reg;
            mem_req.wdata = climb_val;
            val_next      = climb_val;
            if (idx_reg == '0) begin
                state_next = ST_DONE;
            end else begin
                mem_req.raddr = sibling(idx_reg);
                state_next    = ST_CLIMB;
            end
        end
    end

    assign res.page_start = start_reg;
    assign res.status     = status_reg;

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            lvl_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            pos_reg   <= pos_next;
        end
        item_reg   <= item_next;
        r_reg      <= r_next;
        target_reg <= target_next;
        p_reg      <= p_next;
        idx_reg    <= idx_next;
        depth_reg  <= depth_next;
        val_reg    <= val_next;
        start_reg  <= start_next;
        status_reg <= status_next;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    import bpa_pkg::*;

    localparam int RANDOM_WORDS = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIRECTED_ROWS = 21;

    // one directed row; exp_* fields only count when known is set
    typedef struct packed {
        logic               known;
        logic               action;
        logic [COUNT_W-1:0] count;
        logic [PAGE_W-1:0]  page;
        logic [PAGE_W-1:0]  exp_start;
        status_t            exp_status;
    } probe_t;

    // a block the allocator has granted and not yet taken back
    typedef struct {
        int unsigned start;
        int unsigned order;
    } block_t;

    localparam probe_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b1, ACTION_ALLOC, 16'd0,     10'd0,    10'd0, STATUS_BAD_COUNT},
        '{1'b1, ACTION_FREE,  16'd0,     10'd0,    10'd0, STATUS_BAD_COUNT},
        '{1'b1, ACTION_ALLOC, 16'd1025,  10'd0,    10'd0, STATUS_BAD_COUNT},
        '{1'b1, ACTION_ALLOC, 16'd65535, 10'd1023, 10'd0, STATUS_BAD_COUNT},
        '{1'b1, ACTION_FREE,  16'd65535, 10'd1023, 10'd0, STATUS_BAD_COUNT},
        '{1'b1, ACTION_FREE,  16'd1,     10'd0,    10'd0, STATUS_NOT_ALLOC},
        '{1'b1, ACTION_ALLOC, 16'd1024,  10'd0,    10'd0, STATUS_OK},
        '{1'b1, ACTION_ALLOC, 16'd1,     10'd0,    10'd0, STATUS_NO_FREE},
        '{1'b1, ACTION_FREE,  16'd1024,  10'd1023, 10'd0, STATUS_OK},
        '{1'b1, ACTION_ALLOC, 16'd1,     10'd0,    10'd0, STATUS_OK},
        '{1'b0, ACTION_ALLOC, 16'd3,     10'd0,    10'd0, STATUS_OK},
        '{1'b0, ACTION_ALLOC, 16'd512,   10'd0,    10'd0, STATUS_OK},
        '{1'b0, ACTION_FREE,  16'd2,     10'd0,    10'd0, STATUS_OK},
        '{1'b0, ACTION_FREE,  16'd1024,  10'd0,    10'd0, STATUS_OK},
        '{1'b0, ACTION_ALLOC, 16'd600,   10'd0,    10'd0, STATUS_OK},
        '{1'b0, ACTION_FREE,  16'd4,     10'd5,    10'd0, STATUS_OK},
        '{1'b0, ACTION_FREE,  16'd4,     10'd4,    10'd0, STATUS_OK},
        '{1'b0, ACTION_FREE,  16'd512,   10'd512,  10'd0, STATUS_OK},
        '{1'b0, ACTION_FREE,  16'd1,     10'd0,    10'd0, STATUS_OK},
        '{1'b0, ACTION_ALLOC, 16'd1023,  10'd0,    10'd0, STATUS_OK},
        '{1'b0, ACTION_FREE,  16'd513,   10'd700,  10'd0, STATUS_OK}
    };

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    bpa_in_t   s_item;
    logic      m_valid;
    logic      m_ready;
    bpa_out_t  m_result;

    // largest free block below each node, as the allocator should see it
    logic [VAL_W-1:0] largest_free [NODE_COUNT];
    bpa_out_t         pending_results [$];
    block_t           live_blocks [$];

    logic steady;
    int   mismatches;
    int   words_sent;
    int   results_seen;
    int   grants;
    int   frees;
    int   refusals;

    buddy_page_allocator_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void tree_clear();
        for (int d = 0; d <= POOL_LEVELS; d++) begin
            for (int k = 0; k < (1 << d); k++) begin
                largest_free[(1 << d) - 1 + k] = VAL_W'(POOL_PAGES >> d);
            end
        end
    endfunction

    // recompute every ancestor of a node at the given depth
    function automatic void fix_ancestors(input int unsigned node, input int unsigned depth);
        int unsigned up;
        int unsigned half;
        int unsigned lval;
        int unsigned rval;
        while (node > 0 && depth > 0) begin
            up    = (node - 1) / 2;
            depth = depth - 1;
            half  = POOL_PAGES >> (depth + 1);
            lval  = largest_free[2 * up + 1];
            rval  = largest_free[2 * up + 2];
            if (lval == half && rval == half) begin
                largest_free[up] = VAL_W'(2 * half);
            end else begin
                largest_free[up] = VAL_W'((lval > rval) ? lval : rval);
            end
            node = up;
        end
    endfunction

    function automatic int unsigned order_of(input int unsigned count);
        int unsigned lg;
        lg = 0;
        while ((1 << lg) < count) lg++;
        return lg;
    endfunction

    // apply one word to the tree and return the result it must produce
    function automatic bpa_out_t predict_word(input bpa_in_t w);
        int unsigned lg;
        int unsigned size;
        int unsigned target;
        int unsigned node;
        int unsigned page;
        logic        held;
        bpa_out_t    res;
        res.page_start = '0;
        res.status     = STATUS_OK;
        if (w.page_count == 0 || w.page_count > POOL_PAGES) begin
            res.status = STATUS_BAD_COUNT;
        end else begin
            lg     = order_of(w.page_count);
            size   = 1 << lg;
            target = POOL_LEVELS - lg;
            if (w.action == ACTION_ALLOC) begin
                if (largest_free[0] < size) begin
                    res.status = STATUS_NO_FREE;
                end else begin
                    // first fit, left child first
                    node = 0;
                    for (int d = 0; d < target; d++) begin
                        node = (largest_free[2 * node + 1] >= size) ? 2 * node + 1 : 2 * node + 2;
                    end
                    if (largest_free[node] != size) begin
                        res.status = STATUS_NO_FREE;
                    end else begin
                        largest_free[node] = '0;
                        fix_ancestors(node, target);
                        res.page_start = PAGE_W'((node - ((1 << target) - 1)) << lg);
                    end
                end
            end else begin
                page = w.first_page & (POOL_PAGES - 1);
                node = ((1 << target) - 1) + (page >> lg);
                held = (largest_free[node] == 0);
                // a full node is a real allocation only if its left half is still whole
                if (held && target < POOL_LEVELS) begin
                    held = (largest_free[2 * node + 1] == (size >> 1));
                end
                if (!held) begin
                    res.status = STATUS_NOT_ALLOC;
                end else begin
                    largest_free[node] = VAL_W'(size);
                    fix_ancestors(node, target);
                end
            end
        end
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // block order, weighted toward small blocks
    function automatic int unsigned pick_order();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 60) return $urandom_range(1, 2);
        if (r < 85) return $urandom_range(3, 5);
        if (r < 97) return $urandom_range(6, 9);
        return POOL_LEVELS;
    endfunction

    // any count that rounds up to the given order
    function automatic logic [COUNT_W-1:0] pick_count(input int unsigned lg);
        if (lg == 0) return COUNT_W'(1);
        return COUNT_W'($urandom_range((1 << (lg - 1)) + 1, 1 << lg));
    endfunction

    function automatic bpa_in_t make_random_word();
        int unsigned sel;
        int unsigned k;
        int unsigned lg;
        bpa_in_t     w;
        sel          = $urandom_range(0, 99);
        w.action     = ACTION_ALLOC;
        w.first_page = PAGE_W'($urandom_range(0, POOL_PAGES - 1));
        if (sel < 88 && (sel < 50 || live_blocks.size() == 0)) begin
            w.page_count = pick_count(pick_order());
        end else if (sel < 88) begin
            // release a live block, possibly by an unaligned page inside it
            k            = $urandom_range(0, live_blocks.size() - 1);
            lg           = live_blocks[k].order;
            w.action     = ACTION_FREE;
            w.page_count = pick_count(lg);
            w.first_page = PAGE_W'(live_blocks[k].start + $urandom_range(0, (1 << lg) - 1));
        end else if (sel < 94) begin
            // free with a size or place that is likely wrong
            w.action     = ACTION_FREE;
            w.page_count = pick_count(pick_order());
        end else begin
            w.action     = 1'($urandom_range(0, 1));
            w.page_count = COUNT_W'($urandom_range(0, 65535));
        end
        return w;
    endfunction

    task automatic idle_gap();
        int unsigned n;
        n = gap_len();
        if (n > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // present one word, wait for the handshake, then record what must come back
    task automatic send_word(input bpa_in_t w, input logic typed, input bpa_out_t typed_res);
        bpa_out_t    model_res;
        int unsigned lg;
        int unsigned aligned;
        @(negedge aclk);
        s_item  = w;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        model_res = predict_word(w);
        pending_results.push_back(typed ? typed_res : model_res);
        words_sent++;
        // keep the list of live blocks in step with the tree
        if (model_res.status == STATUS_OK) begin
            lg = order_of(w.page_count);
            if (w.action == ACTION_ALLOC) begin
                live_blocks.push_back('{model_res.page_start, lg});
            end else begin
                aligned = ((w.first_page & (POOL_PAGES - 1)) >> lg) << lg;
                for (int i = 0; i < live_blocks.size(); i++) begin
                    if (live_blocks[i].start == aligned && live_blocks[i].order == lg) begin
                        live_blocks.delete(i);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // result side stalls
    initial begin
        int unsigned stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready    = 1'b0;
                stall_left = stall_left - 1;
            end else begin
                m_ready = 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin
        bpa_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, got start %0d status %s",
                         $time, m_result.page_start, m_result.status.name());
            end else begin
                want = pending_results.pop_front();
                if (m_result.page_start !== want.page_start) begin
                    mismatches++;
                    $display("%0t: result %0d page_start expected %0d got %0d",
                             $time, results_seen, want.page_start, m_result.page_start);
                end
                if (m_result.status !== want.status) begin
                    mismatches++;
                    $display("%0t: result %0d status expected %s got %0d",
                             $time, results_seen, want.status.name(), m_result.status);
                end
                case (want.status)
                    STATUS_OK: begin
                        if (m_result.page_start == want.page_start) grants = grants;
                    end
                    default: refusals++;
                endcase
            end
        end
    end

    // stimulus
    initial begin
        bpa_in_t  w;
        bpa_out_t typed_res;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_item       = '0;
        steady       = 1'b0;
        mismatches   = 0;
        words_sent   = 0;
        results_seen = 0;
        grants       = 0;
        frees        = 0;
        refusals     = 0;
        tree_clear();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            w.action             = DIRECTED[i].action;
            w.page_count         = DIRECTED[i].count;
            w.first_page         = DIRECTED[i].page;
            typed_res.page_start = DIRECTED[i].exp_start;
            typed_res.status     = DIRECTED[i].exp_status;
            send_word(w, DIRECTED[i].known, typed_res);
            idle_gap();
        end

        // random traffic, mostly well-formed alloc/free pairs
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady = ((n % 100) >= 70);
            if (n % 150 == 75) begin
                @(negedge aclk);
                s_valid = 1'b0;
                wait_drained();
                repeat (DRAIN_CYCLES) @(posedge aclk);
            end
            w = make_random_word();
            if (w.action == ACTION_ALLOC) grants++;
            else frees++;
            send_word(w, 1'b0, typed_res);
            idle_gap();
        end
        steady = 1'b0;

        @(negedge aclk);
        s_valid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d words (%0d directed): %0d random allocate and %0d random free",
                 words_sent, DIRECTED_ROWS, grants, frees);
        $display("requests, %0d refused with an error status, %0d blocks still held at the end",
                 refusals, live_blocks.size());
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
